>>> hdl/bpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared constants, codes and controller/datapath signal groups for the
// bitmap page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_PAGES  = 4096;
  localparam int DEF_PAGE_BYTES = 4096;

  // Map word geometry
  localparam int WORD_BITS  = 64;
  localparam int WORD_SHIFT = 6;

  // Field widths
  localparam int CNT_W     = 13;
  localparam int ADDR_W    = 48;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 1;

  // Reset value of the pages_in_use register
  localparam int CFG_PAGES_RST = 4096;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PAGES_IN_USE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEMORY_BASE  = 1'd1;

  // Request opcodes
  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } bpa_op_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_NO_RUN = 2'd1,
    ST_OOB    = 2'd2
  } bpa_status_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic        latch_req;
    logic        clr_write;
    logic        clr_next;
    logic        scan_start;
    logic        free_sub;
    logic        free_chk;
    logic        upd_start;
    logic        upd_write;
    logic        upd_next;
    logic        load_rsp;
    bpa_status_t code;
  } bpa_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clr_last;
    logic is_free;
    logic cnt_zero;
    logic lim_zero;
    logic oob;
    logic scan_done;
    logic scan_hit;
    logic scan_busy;
    logic upd_full;
    logic upd_last;
    logic out_busy;
  } bpa_stat_t;

endpackage

>>> hdl/bpa_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_req_if
// Request channel: valid/ready handshake with opcode, page count and address.
// ----------------------------------------------------------------------------
interface bpa_req_if import bpa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [CNT_W-1:0]  page_count;
  logic [ADDR_W-1:0] address;

  modport source (output valid, cmd, page_count, address, input ready);
  modport sink   (input valid, cmd, page_count, address, output ready);
endinterface

>>> hdl/bpa_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_rsp_if
// Result channel: valid/ready handshake with status and run address.
// ----------------------------------------------------------------------------
interface bpa_rsp_if import bpa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0]   run_address;

  modport source (output valid, status, run_address, input ready);
  modport sink   (input valid, status, run_address, output ready);
endinterface

>>> hdl/bitmap_page_allocator.sv
`timescale 1ns / 1ps
// Allocate: decode, scan W map words one per cycle (64 at most by default), then
//   update the run word by word: full words written directly, edge words read first.
// Free: decode, range check, update. Failed scans, failed or zero-count frees, and
//   zero-count or zero-page allocates skip the update. One item at a time: the
//   next is accepted in the cycle after the result is loaded; the result register
//   lets it in before pickup. Reset: synchronous; a sweep clears the map.
// ----------------------------------------------------------------------------
// bitmap_page_allocator
// First-fit physical page allocator over a one-bit-per-page map, built as a
// controller state machine driving a scan and update datapath.
// ----------------------------------------------------------------------------
module bitmap_page_allocator import bpa_pkg::*; #(
  parameter int MAX_PAGES  = DEF_MAX_PAGES,
  parameter int PAGE_BYTES = DEF_PAGE_BYTES
) (
  input  logic                 clk,
  input  logic                 rst,
  bpa_req_if.sink              req,
  bpa_rsp_if.source            rsp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data
);

  bpa_cmd_t    cmd;
  bpa_stat_t   stat;
  bpa_status_t out_status;

  // Sequencer
  bpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Map, scan and update datapath
  bpa_datapath #(
    .MAX_PAGES  (MAX_PAGES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .in_cmd          (req.cmd),
    .in_count        (req.page_count),
    .in_address      (req.address),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (rsp.valid),
    .out_ready       (rsp.ready),
    .out_status      (out_status),
    .out_run_address (rsp.run_address)
  );

  assign rsp.status = out_status;

  // A loaded result is offered on the next cycle
  a_rsp_load: assert property (@(posedge clk) disable iff (rst)
    cmd.load_rsp |=> rsp.valid)
    else $error("result loaded but not offered");

  // Failed requests and frees never report an address
  a_addr_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.status != ST_OK)) |-> (rsp.run_address == '0))
    else $error("address on a failed result");

  // The map is never written while a scan is reading it
  a_no_wr_scan: assert property (@(posedge clk) disable iff (rst)
    !(cmd.upd_write && stat.scan_busy))
    else $error("map write during scan");

  // One item in flight: no accept in the cycle after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("second item accepted while busy");

endmodule

>>> hdl/bpa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_ctrl
// Sequencer for the allocator: reset sweep, request decode, map scan,
// free range check, word-by-word map update and result hand-off.
// ----------------------------------------------------------------------------
module bpa_ctrl import bpa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  bpa_stat_t stat,
  output bpa_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_FREE_CHK,
    S_SETUP,
    S_UPD,
    S_UPD_WR,
    S_RESP
  } state_t;

  state_t      state, state_next;
  bpa_status_t code, code_next;

  assign in_ready = (state == S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    code_next  = code;
    cmd        = '0;
    cmd.code   = code;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_write = 1'b1;
        cmd.clr_next  = 1'b1;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_req = 1'b1;
          state_next    = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.is_free) begin
          cmd.free_sub = 1'b1;
          state_next   = S_FREE_CHK;
        end else if (stat.cnt_zero || stat.lim_zero) begin
          code_next  = ST_NO_RUN;
          state_next = S_RESP;
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          if (stat.scan_hit) begin
            code_next  = ST_OK;
            state_next = S_SETUP;
          end else begin
            code_next  = ST_NO_RUN;
            state_next = S_RESP;
          end
        end
      end
      S_FREE_CHK: begin
        cmd.free_chk = 1'b1;
        if (stat.oob) begin
          code_next  = ST_OOB;
          state_next = S_RESP;
        end else begin
          code_next  = ST_OK;
          state_next = stat.cnt_zero ? S_RESP : S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.upd_start = 1'b1;
        state_next    = S_UPD;
      end
      S_UPD: begin
        // whole words are written directly, edge words wait for read data
        if (stat.upd_full) begin
          cmd.upd_write = 1'b1;
          if (stat.upd_last) begin
            state_next = S_RESP;
          end else begin
            cmd.upd_next = 1'b1;
          end
        end else begin
          state_next = S_UPD_WR;
        end
      end
      S_UPD_WR: begin
        cmd.upd_write = 1'b1;
        if (stat.upd_last) begin
          state_next = S_RESP;
        end else begin
          cmd.upd_next = 1'b1;
          state_next   = S_UPD;
        end
      end
      S_RESP: begin
        if (!stat.out_busy) begin
          cmd.load_rsp = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State and result code
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      code  <= ST_OK;
    end else begin
      state <= state_next;
      code  <= code_next;
    end
  end

endmodule

>>> hdl/bpa_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_datapath
// Page map memory, configuration registers, pipelined first-fit scan over
// map words, free range check, range mask update and result register.
// ----------------------------------------------------------------------------
module bpa_datapath import bpa_pkg::*; #(
  parameter int MAX_PAGES  = DEF_MAX_PAGES,
  parameter int PAGE_BYTES = DEF_PAGE_BYTES
) (
  input  logic                 clk,
  input  logic                 rst,
  input  bpa_cmd_t             cmd,
  output bpa_stat_t            stat,
  // request payload
  input  logic                 in_cmd,
  input  logic [CNT_W-1:0]     in_count,
  input  logic [ADDR_W-1:0]    in_address,
  // configuration writes
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data,
  // result register
  output logic                 out_valid,
  input  logic                 out_ready,
  output bpa_status_t          out_status,
  output logic [ADDR_W-1:0]    out_run_address
);

  localparam int MAP_WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int WAW       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int FW        = WAW + WORD_SHIFT;
  localparam int PW        = $clog2(MAX_PAGES + 1);
  localparam int CW        = (PW > CNT_W) ? PW : CNT_W;
  localparam int PB_SHIFT  = $clog2(PAGE_BYTES);
  localparam int PGW       = ADDR_W - PB_SHIFT;
  localparam int SW        = ((PGW > CW) ? PGW : CW) + 1;
  localparam int LIMIT_RST = (CFG_PAGES_RST > MAX_PAGES) ? MAX_PAGES : CFG_PAGES_RST;

  localparam logic [WAW-1:0]        LAST_WORD = WAW'(MAP_WORDS - 1);
  localparam logic [WORD_BITS-1:0]  ONES      = {WORD_BITS{1'b1}};

  // Number of set bits from bit 0 upward before the first clear bit
  function automatic logic [WORD_SHIFT:0] low_ones(input logic [WORD_BITS-1:0] v);
    logic [WORD_SHIFT:0] n;
    n = (WORD_SHIFT + 1)'(WORD_BITS);
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!v[i]) n = (WORD_SHIFT + 1)'(i);
    end
    return n;
  endfunction

  // Number of set bits from the top bit downward before the first clear bit
  function automatic logic [WORD_SHIFT:0] high_ones(input logic [WORD_BITS-1:0] v);
    logic [WORD_SHIFT:0] n;
    n = (WORD_SHIFT + 1)'(WORD_BITS);
    for (int i = 0; i < WORD_BITS; i++) begin
      if (!v[i]) n = (WORD_SHIFT + 1)'(WORD_BITS - 1 - i);
    end
    return n;
  endfunction

  // Position of the lowest set bit
  function automatic logic [WORD_SHIFT-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
    logic [WORD_SHIFT-1:0] n;
    n = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) n = WORD_SHIFT'(i);
    end
    return n;
  endfunction

  // Position of the highest set bit of a small count
  function automatic logic [2:0] msb_pos(input logic [WORD_SHIFT-1:0] v);
    logic [2:0] n;
    n = '0;
    for (int i = 0; i < WORD_SHIFT; i++) begin
      if (v[i]) n = 3'(i);
    end
    return n;
  endfunction

  // Configuration
  logic [PW-1:0]     limit;
  logic [ADDR_W-1:0] base;
  logic [CW-1:0]     cfg_pages;

  assign cfg_pages = CW'(cfg_data[CNT_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= PW'(LIMIT_RST);
      base  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PAGES_IN_USE: limit <= (cfg_pages > CW'(MAX_PAGES)) ? PW'(MAX_PAGES)
                                                                : PW'(cfg_pages);
        REG_MEMORY_BASE:  base  <= cfg_data;
      endcase
    end
  end

  // Request latch with per-request scan setup
  logic                  req_op;
  logic [CNT_W-1:0]      req_cnt;
  logic [ADDR_W-1:0]     req_addr;
  logic                  inner_en;
  logic [2:0]            inner_m;
  logic [WORD_SHIFT-1:0] inner_d;
  logic [WAW-1:0]        last_w;
  logic [WORD_BITS-1:0]  tail_mask;
  logic [2:0]            in_m;
  logic [PW-1:0]         lim_m1;

  assign in_m   = msb_pos(in_count[WORD_SHIFT-1:0]);
  assign lim_m1 = limit - 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.latch_req) begin
      req_op    <= in_cmd;
      req_cnt   <= in_count;
      req_addr  <= in_address;
      inner_en  <= (in_count < CNT_W'(WORD_BITS));
      inner_m   <= in_m;
      inner_d   <= in_count[WORD_SHIFT-1:0] ^ (WORD_SHIFT'(1) << in_m);
      last_w    <= WAW'(lim_m1 >> WORD_SHIFT);
      tail_mask <= (limit[WORD_SHIFT-1:0] == '0) ? ONES
                                                 : ~(ONES << limit[WORD_SHIFT-1:0]);
    end
  end

  // Page map memory
  logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
  logic                 mem_we;
  logic [WAW-1:0]       mem_waddr;
  logic [WAW-1:0]       mem_raddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [WORD_BITS-1:0] rdata;

  always_ff @(posedge clk) begin
    if (mem_we) map_mem[mem_waddr] <= mem_wdata;
    rdata <= map_mem[mem_raddr];
  end

  // Reset clearing sweep
  logic [WAW-1:0] clr_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_w <= '0;
    end else if (cmd.clr_next) begin
      clr_w <= clr_w + 1'b1;
    end
  end

  // Scan stage 2: free bits of the word just read, runs inside the word
  logic                  scan_iss;
  logic [WAW-1:0]        rd_ptr;
  logic                  v1, v2;
  logic [WAW-1:0]        w1, w2;
  logic [WORD_BITS-1:0]  word_free;
  logic [WORD_BITS-1:0]  e1, e2, e4, e8, e16, e32, em, r_mask;

  assign word_free = ~rdata & ((w1 == last_w) ? tail_mask : ONES);
  assign e1  = word_free;
  assign e2  = e1 & (e1 >> 1);
  assign e4  = e2 & (e2 >> 2);
  assign e8  = e4 & (e4 >> 4);
  assign e16 = e8 & (e8 >> 8);
  assign e32 = e16 & (e16 >> 16);

  // Two overlapping windows of the largest power of two cover the count
  always_comb begin
    unique case (inner_m)
      3'd0:    em = e1;
      3'd1:    em = e2;
      3'd2:    em = e4;
      3'd3:    em = e8;
      3'd4:    em = e16;
      default: em = e32;
    endcase
  end

  assign r_mask = inner_en ? (em & (em >> inner_d)) : '0;

  // Scan stage 3: run tracking across words
  logic [WORD_BITS-1:0]  a_r;
  logic [WORD_SHIFT:0]   a_tz, a_lz;
  logic [PW-1:0]         run;
  logic [FW-1:0]         run_first;
  logic                  done, hit;
  logic [FW-1:0]         first;
  logic [FW-1:0]         base_w;
  logic                  hit_carry, hit_now, hit_evt, all_free;
  logic [FW-1:0]         hit_first;

  assign base_w    = {w2, {WORD_SHIFT{1'b0}}};
  assign hit_carry = ((CW + 1)'(run) + (CW + 1)'(a_tz)) >= (CW + 1)'(req_cnt);
  assign hit_now   = hit_carry || (a_r != '0);
  assign hit_evt   = v2 && !done && hit_now;
  assign all_free  = (a_tz == (WORD_SHIFT + 1)'(WORD_BITS));
  assign hit_first = hit_carry ? ((run != '0) ? run_first : base_w)
                               : {w2, lowest_set(a_r)};

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_iss <= 1'b0;
      v1       <= 1'b0;
      v2       <= 1'b0;
      done     <= 1'b0;
      hit      <= 1'b0;
    end else if (cmd.scan_start) begin
      scan_iss <= 1'b1;
      rd_ptr   <= '0;
      v1       <= 1'b0;
      v2       <= 1'b0;
      done     <= 1'b0;
      hit      <= 1'b0;
      run      <= '0;
    end else begin
      // issue one map read per cycle, stop at the last word or on a hit
      if (scan_iss) begin
        if (hit_evt || (rd_ptr == last_w)) scan_iss <= 1'b0;
        else                               rd_ptr   <= rd_ptr + 1'b1;
      end
      v1   <= scan_iss && !hit_evt;
      w1   <= rd_ptr;
      v2   <= v1 && !hit_evt;
      w2   <= w1;
      a_r  <= r_mask;
      a_tz <= low_ones(word_free);
      a_lz <= high_ones(word_free);
      // evaluate, flush reads in flight on a hit
      if (v2 && !done) begin
        if (hit_now) begin
          done     <= 1'b1;
          hit      <= 1'b1;
        end else begin
          if (all_free) begin
            run       <= run + PW'(WORD_BITS);
            run_first <= (run == '0) ? base_w : run_first;
          end else begin
            run       <= PW'(a_lz);
            run_first <= {w2, WORD_SHIFT'((WORD_SHIFT + 1)'(WORD_BITS) - a_lz)};
          end
          if (w2 == last_w) done <= 1'b1;
        end
      end
    end
  end

  // Free: offset from base, then range check against the usable pages
  logic              sub_below;
  logic [ADDR_W-1:0] sub_off;
  logic [ADDR_W:0]   diff;
  logic [PGW-1:0]    page;
  logic [SW-1:0]     page_end;
  logic              oob;

  assign diff     = {1'b0, req_addr} - {1'b0, base};
  assign page     = sub_off[ADDR_W-1:PB_SHIFT];
  assign page_end = SW'(page) + SW'(req_cnt);
  assign oob      = sub_below || (page_end > SW'(limit));

  always_ff @(posedge clk) begin
    if (cmd.free_sub) begin
      sub_below <= diff[ADDR_W];
      sub_off   <= diff[ADDR_W-1:0];
    end
  end

  // Start page of the range to mark or clear
  always_ff @(posedge clk) begin
    if (hit_evt) begin
      first <= hit_first;
    end else if (cmd.free_chk) begin
      first <= FW'(page);
    end
  end

  // Range update, one map word at a time
  logic [WAW-1:0]        upd_w;
  logic [FW-1:0]         rng_last;
  logic [CW:0]           rng_sum;
  logic [WORD_SHIFT-1:0] lo, hi;
  logic [WORD_BITS-1:0]  upd_mask, upd_data;
  logic                  upd_full, upd_last, set_bits;

  assign rng_sum  = (CW + 1)'(first) + (CW + 1)'(req_cnt) - 1'b1;
  assign lo       = (upd_w == first[FW-1:WORD_SHIFT]) ? first[WORD_SHIFT-1:0] : '0;
  assign upd_last = (upd_w == rng_last[FW-1:WORD_SHIFT]);
  assign hi       = upd_last ? rng_last[WORD_SHIFT-1:0] : '1;
  assign upd_mask = (ONES << lo) & (ONES >> (~hi));
  assign upd_full = (lo == '0) && (hi == '1);
  assign set_bits = (req_op == OP_ALLOC);
  assign upd_data = upd_full ? (set_bits ? ONES : '0)
                             : (set_bits ? (rdata | upd_mask) : (rdata & ~upd_mask));

  always_ff @(posedge clk) begin
    if (cmd.upd_start) begin
      rng_last <= rng_sum[FW-1:0];
      upd_w    <= first[FW-1:WORD_SHIFT];
    end else if (cmd.upd_next) begin
      upd_w    <= upd_w + 1'b1;
    end
  end

  // Memory port selection
  assign mem_we    = cmd.clr_write || cmd.upd_write;
  assign mem_waddr = cmd.clr_write ? clr_w : upd_w;
  assign mem_wdata = cmd.clr_write ? '0 : upd_data;
  assign mem_raddr = scan_iss ? rd_ptr : upd_w;

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_rsp) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_rsp) begin
      out_status      <= cmd.code;
      out_run_address <= ((cmd.code == ST_OK) && set_bits)
                         ? base + (ADDR_W'(first) << PB_SHIFT) : '0;
    end
  end

  // Status to the controller
  assign stat.clr_last  = (clr_w == LAST_WORD);
  assign stat.is_free   = (req_op == OP_FREE);
  assign stat.cnt_zero  = (req_cnt == '0);
  assign stat.lim_zero  = (limit == '0);
  assign stat.oob       = oob;
  assign stat.scan_done = done;
  assign stat.scan_hit  = hit;
  assign stat.scan_busy = scan_iss || v1 || v2;
  assign stat.upd_full  = upd_full;
  assign stat.upd_last  = upd_last;
  assign stat.out_busy  = out_valid && !out_ready;

endmodule

>>> tb/bitmap_page_allocator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_page_allocator_test
// Self-checking bench for the first-fit page allocator. A short table of
// directed requests runs first, then random phases that each start with a
// new page count and memory base. Every accepted request goes through a
// bit-level copy of the page map; results are checked in order, field by field.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_test;
  import bpa_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int N_DIRECTED  = 25;
  localparam int N_PHASES    = 6;

  // One row of the directed table; typed rows carry their own answer
  typedef struct packed {
    bpa_op_t           op;
    logic [CNT_W-1:0]  count;
    logic [ADDR_W-1:0] address;
    logic              typed;
    bpa_status_t       status;
    logic [ADDR_W-1:0] run_address;
  } dir_row_t;

  typedef struct packed {
    bpa_status_t       status;
    logic [ADDR_W-1:0] run_address;
  } page_reply_t;

  typedef struct {
    int unsigned first;
    int unsigned count;
  } page_run_t;

  localparam dir_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{OP_ALLOC, 13'd0,    48'h0,             1'b1, ST_NO_RUN, 48'h0},
    '{OP_ALLOC, 13'd1,    48'h0,             1'b1, ST_OK,     48'h0},
    '{OP_ALLOC, 13'd1,    48'h0,             1'b1, ST_OK,     48'h1000},
    '{OP_ALLOC, 13'd62,   48'h0,             1'b1, ST_OK,     48'h2000},
    '{OP_ALLOC, 13'd4096, 48'h0,             1'b1, ST_NO_RUN, 48'h0},
    '{OP_FREE,  13'd1,    48'h1000,          1'b1, ST_OK,     48'h0},
    '{OP_ALLOC, 13'd2,    48'h0,             1'b0, ST_OK,     48'h0},
    '{OP_ALLOC, 13'd1,    48'h0,             1'b1, ST_OK,     48'h1000},
    '{OP_FREE,  13'd0,    48'h0,             1'b1, ST_OK,     48'h0},
    '{OP_FREE,  13'd1,    48'h100_0000,      1'b1, ST_OOB,    48'h0},
    '{OP_FREE,  13'd0,    48'h100_0000,      1'b1, ST_OK,     48'h0},
    '{OP_FREE,  13'd8191, 48'hFFFF_FFFF_FFFF, 1'b1, ST_OOB,    48'h0},
    '{OP_FREE,  13'd1,    48'h2FFF,          1'b1, ST_OK,     48'h0},
    '{OP_ALLOC, 13'd1,    48'h0,             1'b1, ST_OK,     48'h2000},
    '{OP_FREE,  13'd4096, 48'h0,             1'b1, ST_OK,     48'h0},
    '{OP_ALLOC, 13'd4096, 48'h0,             1'b1, ST_OK,     48'h0},
    '{OP_ALLOC, 13'd1,    48'h0,             1'b1, ST_NO_RUN, 48'h0},
    '{OP_FREE,  13'd4,    48'h5000,          1'b1, ST_OK,     48'h0},
    '{OP_FREE,  13'd4,    48'h5000,          1'b1, ST_OK,     48'h0},
    '{OP_ALLOC, 13'd5,    48'h0,             1'b1, ST_NO_RUN, 48'h0},
    '{OP_ALLOC, 13'd4,    48'h0,             1'b1, ST_OK,     48'h5000},
    '{OP_ALLOC, 13'd8191, 48'h0,             1'b1, ST_NO_RUN, 48'h0},
    '{OP_FREE,  13'd8191, 48'h0,             1'b1, ST_OOB,    48'h0},
    '{OP_FREE,  13'd3,    48'h7000,          1'b0, ST_OK,     48'h0},
    '{OP_ALLOC, 13'd3,    48'hFFFF_FFFF_FFFF, 1'b0, ST_OK,     48'h0}
  };

  // Register settings per random phase: values above the map size, zero
  // pages, top-of-space base (address wrap) and an unaligned base
  localparam logic [CNT_W-1:0] PHASE_PAGES [N_PHASES] = '{
    13'd4096, 13'd100, 13'd0, 13'd8191, 13'd64, 13'd4096
  };
  localparam logic [ADDR_W-1:0] PHASE_BASE [N_PHASES] = '{
    48'h0000_8000_0000, 48'hFFFF_FFFF_F000, 48'h0000_1234_5000,
    48'h0000_0000_0003, 48'h0,              48'h7FFF_0000_0000
  };
  localparam int PHASE_ITEMS [N_PHASES] = '{230, 220, 120, 260, 220, 260};

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ADDR_W-1:0]    cfg_data;

  bpa_req_if req_ch ();
  bpa_rsp_if rsp_ch ();

  bitmap_page_allocator u_top (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow state of the allocator
  bit [DEF_MAX_PAGES-1:0] page_map;
  logic [CNT_W-1:0]       pages_in_use;
  logic [ADDR_W-1:0]      memory_base;

  page_reply_t page_reply_q [$];
  page_run_t   live_runs [$];
  int          fail_cnt;
  int          cycle_cnt;
  int          snd_idle;
  int          rcv_idle;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [ADDR_W-1:0] rand48();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[ADDR_W-1:0];
  endfunction

  function automatic int unsigned usable_pages();
    return (pages_in_use > DEF_MAX_PAGES) ? DEF_MAX_PAGES : int'(pages_in_use);
  endfunction

  // First-fit allocate / range free on the shadow map
  function automatic void apply_page_request(input bpa_op_t op,
                                             input logic [CNT_W-1:0] count,
                                             input logic [ADDR_W-1:0] address,
                                             output page_reply_t reply);
    longint unsigned limit;
    longint unsigned page;
    longint unsigned first;
    longint unsigned run;
    logic [ADDR_W-1:0] offset;
    bit hit;
    limit = usable_pages();
    reply = '{status: ST_OK, run_address: '0};
    first = 0;
    run   = 0;
    hit   = 1'b0;
    if (op == OP_ALLOC) begin
      if (count != 0) begin
        for (longint unsigned i = 0; i < limit && !hit; i++) begin
          if (page_map[i]) begin
            run = 0;
          end else begin
            if (run == 0) first = i;
            run++;
            if (run == count) hit = 1'b1;
          end
        end
      end
      if (hit) begin
        for (longint unsigned i = first; i < first + count; i++) page_map[i] = 1'b1;
        reply.run_address = memory_base + (ADDR_W'(first) << 12);
        live_runs.push_back('{first: int'(first), count: int'(count)});
        if (live_runs.size() > 200) void'(live_runs.pop_front());
      end else begin
        reply.status = ST_NO_RUN;
      end
    end else begin
      if (address < memory_base) begin
        reply.status = ST_OOB;
      end else begin
        offset = address - memory_base;
        page   = offset / DEF_PAGE_BYTES;
        if (page > limit || count > limit - page) begin
          reply.status = ST_OOB;
        end else begin
          for (longint unsigned i = page; i < page + count; i++) page_map[i] = 1'b0;
        end
      end
    end
  endfunction

  // Present one request, hold it until accepted, then record what must come back
  task automatic send_request(input bpa_op_t op, input logic [CNT_W-1:0] count,
                              input logic [ADDR_W-1:0] address, input logic typed,
                              input page_reply_t typed_reply);
    page_reply_t reply;
    if ($urandom_range(99) < snd_idle) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle);
    end
    req_ch.valid      <= 1'b1;
    req_ch.cmd        <= op;
    req_ch.page_count <= count;
    req_ch.address    <= address;
    do @(posedge clk); while (!req_ch.ready);
    apply_page_request(op, count, address, reply);
    page_reply_q.push_back(typed ? typed_reply : reply);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [ADDR_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    if (index == REG_PAGES_IN_USE) pages_in_use = data[CNT_W-1:0];
    else memory_base = data;
    @(posedge clk);
  endtask

  // Let all outstanding items drain before touching the registers
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (page_reply_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // One random item: mostly small allocations and frees of runs handed out
  // earlier, plus arbitrary ranges and raw noise
  task automatic send_random_item();
    int unsigned sel;
    int unsigned lim;
    int unsigned page;
    int unsigned idx;
    page_run_t   pick;
    logic [CNT_W-1:0]  count;
    logic [ADDR_W-1:0] address;
    lim = usable_pages();
    sel = $urandom_range(99);
    if (sel < 50) begin
      case ($urandom_range(49) / 10)
        0, 1, 2: count = CNT_W'($urandom_range(1, 8));
        3:       count = CNT_W'($urandom_range(1, 64));
        default: count = ($urandom_range(9) == 0) ? CNT_W'($urandom_range(0, 8191))
                                                  : CNT_W'($urandom_range(1, 4096));
      endcase
      send_request(OP_ALLOC, count, rand48(), 1'b0, '0);
    end else if (sel < 80 && live_runs.size() != 0) begin
      idx  = $urandom_range(live_runs.size() - 1);
      pick = live_runs[idx];
      live_runs.delete(idx);
      count = CNT_W'(($urandom_range(3) == 0) ? $urandom_range(1, pick.count) : pick.count);
      address = memory_base + (ADDR_W'(pick.first) << 12) + ADDR_W'($urandom_range(4095));
      send_request(OP_FREE, count, address, 1'b0, '0);
    end else if (sel < 90) begin
      page    = $urandom_range(lim);
      count   = CNT_W'($urandom_range(0, lim - page + 1));
      address = memory_base + (ADDR_W'(page) << 12) + ADDR_W'($urandom_range(4095));
      send_request(OP_FREE, count, address, 1'b0, '0);
    end else begin
      count   = CNT_W'($urandom_range(0, 8191));
      // request just below the base, or at a fully random address
      address = ($urandom_range(1) == 0) ? memory_base - ADDR_W'($urandom_range(1, 4096))
                                         : rand48();
      send_request(bpa_op_t'($urandom_range(1)), count, address, 1'b0, '0);
    end
  endtask

  // Result checker and receiver stalls
  initial begin : rsp_check
    page_reply_t want;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (page_reply_q.size() == 0) begin
          $error("result with none pending: status %0d run_address %h",
                 rsp_ch.status, rsp_ch.run_address);
          fail_cnt++;
        end else begin
          want = page_reply_q.pop_front();
          if (rsp_ch.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
            fail_cnt++;
          end
          if (rsp_ch.run_address !== want.run_address) begin
            $error("run_address: expected %h, actual %h",
                   want.run_address, rsp_ch.run_address);
            fail_cnt++;
          end
        end
      end
      rsp_ch.ready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  // Watchdog
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // Stimulus
  initial begin
    fail_cnt     = 0;
    snd_idle     = 13;
    rcv_idle     = 60;
    page_map     = '0;
    pages_in_use = CNT_W'(CFG_PAGES_RST);
    memory_base  = '0;
    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_index         <= REG_PAGES_IN_USE;
    cfg_data          <= '0;
    req_ch.valid      <= 1'b0;
    req_ch.cmd        <= OP_ALLOC;
    req_ch.page_count <= '0;
    req_ch.address    <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed table under reset settings
    for (int r = 0; r < N_DIRECTED; r++) begin
      send_request(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].count, DIRECTED_ROWS[r].address,
                   DIRECTED_ROWS[r].typed,
                   '{status: DIRECTED_ROWS[r].status,
                     run_address: DIRECTED_ROWS[r].run_address});
    end

    // Random phases: receiver-heavy idling, then sender-heavy, then none
    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain();
      write_reg(REG_PAGES_IN_USE, ADDR_W'(PHASE_PAGES[ph]));
      write_reg(REG_MEMORY_BASE, PHASE_BASE[ph]);
      cfg_we <= 1'b0;
      case (ph / 2)
        0:       begin snd_idle = 13; rcv_idle = 60; end
        1:       begin snd_idle = 60; rcv_idle = 13; end
        default: begin snd_idle = 0;  rcv_idle = 0;  end
      endcase
      for (int n = 0; n < PHASE_ITEMS[ph]; n++) send_random_item();
    end

    req_ch.valid <= 1'b0;
    while (page_reply_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> bitmap_page_allocator.f
hdl/bpa_pkg.sv
hdl/bpa_req_if.sv
hdl/bpa_rsp_if.sv
hdl/bpa_ctrl.sv
hdl/bpa_datapath.sv
hdl/bitmap_page_allocator.sv
tb/bitmap_page_allocator_test.sv
